// ===== rtl/obc_pkg.sv =====
package obc_pkg;

   // angle constants in whole degrees
   localparam int unsigned ANGLE_STEPS   = 360;
   localparam int unsigned QUARTER_TURN  = 90;
   localparam int unsigned HALF_TURN     = 180;
   localparam int unsigned THREE_QUARTER = 270;

   // pi in Q2.30 for the table build
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef logic [15:0] sine_table_type [0:90];

   // quarter-wave sine in Q1.15, evaluated at elaboration only
   function automatic sine_table_type build_sine_table();
      sine_table_type    tbl;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic [63:0]       q;
      logic signed [63:0] s;
      for (int k = 0; k <= 90; k++) begin
         x    = 64'(k) * PI_Q30 / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         s    = signed'(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
               s = s - signed'(term);
            end else begin
               s = s + signed'(term);
            end
         end
         if (s < 0) begin
            s = '0;
         end
         q = (unsigned'(s) + 64'd16384) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         tbl[k] = q[15:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // full-circle sine in Q1.15, angle below one turn
   function automatic logic signed [15:0] sine_q15(input logic [8:0] d);
      logic [8:0]  idx;
      logic        neg;
      logic [15:0] mag;
      if (d <= 9'(QUARTER_TURN)) begin
         idx = d;
         neg = 1'b0;
      end else if (d <= 9'(HALF_TURN)) begin
         idx = 9'(HALF_TURN) - d;
         neg = 1'b0;
      end else if (d <= 9'(THREE_QUARTER)) begin
         idx = d - 9'(HALF_TURN);
         neg = 1'b1;
      end else begin
         idx = 9'(ANGLE_STEPS) - d;
         neg = 1'b1;
      end
      mag = SINE_TABLE[idx[6:0]];
      return neg ? -signed'(mag) : signed'(mag);
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CHECK,
      ST_TRIG,
      ST_CENTER_X,
      ST_CENTER_Y,
      ST_DOT_X,
      ST_DOT_Y,
      ST_REACH,
      ST_COMPARE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_STORE,
      OP_LOAD,
      OP_DIFF,
      OP_TRIG,
      OP_CENTER_X,
      OP_CENTER_Y,
      OP_DOT_X,
      OP_DOT_Y,
      OP_REACH,
      OP_HIT,
      OP_MISS
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
      logic [1:0] term;
   } dp_cmd_type;

   typedef struct packed {
      logic reject;
      logic gap;
   } dp_status_type;

endpackage

// ===== rtl/oriented_box_collision_test_core.sv =====
// channel   ports                                  handshake
// request   req_action .. req_bound_radius         start high while busy low
// result    rsp_colliding                          rsp_valid one-cycle strobe
//
// A store request (action 0) is stored while busy stays low.
// A test request ends in one strobe, issued early when the height or radius
// pre-check rejects or an axis shows a gap, else after all four axes, each
// run as 15 steps on the single shared multiplier.
// Reset is synchronous and clears the stored object to zero.
// The receiver cannot stall; each result shows for exactly one cycle.
module oriented_box_collision_test_core #(
   parameter int POSITION_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic signed [POSITION_BITS-1:0] req_pos_x,
   input  logic signed [POSITION_BITS-1:0] req_pos_y,
   input  logic signed [POSITION_BITS-1:0] req_pos_z,
   input  logic [8:0]                      req_heading_deg,
   input  logic [15:0]                     req_width,
   input  logic [15:0]                     req_length,
   input  logic [15:0]                     req_height,
   input  logic [15:0]                     req_bound_radius,
   output logic                            rsp_valid,
   output logic                            rsp_colliding
);
   import obc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   obc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   // arithmetic and object storage
   obc_dp #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_heading_deg  (req_heading_deg),
      .req_width        (req_width),
      .req_length       (req_length),
      .req_height       (req_height),
      .req_bound_radius (req_bound_radius),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_colliding    (rsp_colliding)
   );

endmodule

// ===== rtl/obc_ctrl.sv =====
module obc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_action,
   input  obc_pkg::dp_status_type status,
   output logic                  busy,
   output obc_pkg::dp_cmd_type   cmd
);
   import obc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     axis_ff, axis_in;
   logic [1:0]     term_ff, term_in;

   // state and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         term_ff  <= term_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_action) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            axis_in = '0;
            term_in = '0;
            state_in = status.reject ? ST_IDLE : ST_TRIG;
         end
         ST_TRIG: begin
            term_in = term_ff + 2'd1;
            if (term_ff == 2'd3) begin
               state_in = ST_CENTER_X;
            end
         end
         ST_CENTER_X: begin
            state_in = ST_CENTER_Y;
         end
         ST_CENTER_Y: begin
            state_in = ST_DOT_X;
         end
         ST_DOT_X: begin
            state_in = ST_DOT_Y;
         end
         ST_DOT_Y: begin
            state_in = ST_REACH;
         end
         ST_REACH: begin
            term_in = term_ff + 2'd1;
            state_in = (term_ff == 2'd3) ? ST_COMPARE : ST_DOT_X;
         end
         ST_COMPARE: begin
            if (status.gap || axis_ff == 2'd3) begin
               state_in = ST_IDLE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_CENTER_X;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.op   = OP_IDLE;
      cmd.axis = axis_ff;
      cmd.term = term_ff;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = req_action ? OP_LOAD : OP_STORE;
            end
         end
         ST_DIFF:     cmd.op = OP_DIFF;
         ST_CHECK:    cmd.op = status.reject ? OP_MISS : OP_IDLE;
         ST_TRIG:     cmd.op = OP_TRIG;
         ST_CENTER_X: cmd.op = OP_CENTER_X;
         ST_CENTER_Y: cmd.op = OP_CENTER_Y;
         ST_DOT_X:    cmd.op = OP_DOT_X;
         ST_DOT_Y:    cmd.op = OP_DOT_Y;
         ST_REACH:    cmd.op = OP_REACH;
         ST_COMPARE: begin
            if (status.gap) begin
               cmd.op = OP_MISS;
            end else if (axis_ff == 2'd3) begin
               cmd.op = OP_HIT;
            end
         end
         default:     cmd.op = OP_IDLE;
      endcase
   end

endmodule

// ===== rtl/obc_dp.sv =====
module obc_dp #(
   parameter int POSITION_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  obc_pkg::dp_cmd_type             cmd,
   input  logic signed [POSITION_BITS-1:0] req_pos_x,
   input  logic signed [POSITION_BITS-1:0] req_pos_y,
   input  logic signed [POSITION_BITS-1:0] req_pos_z,
   input  logic [8:0]                      req_heading_deg,
   input  logic [15:0]                     req_width,
   input  logic [15:0]                     req_length,
   input  logic [15:0]                     req_height,
   input  logic [15:0]                     req_bound_radius,
   output obc_pkg::dp_status_type          status,
   output logic                            rsp_valid,
   output logic                            rsp_colliding
);
   import obc_pkg::*;

   localparam int DW = POSITION_BITS + 1;

   // stored first object
   logic [POSITION_BITS-1:0] first_x_ff, first_y_ff, first_z_ff;
   logic [8:0]               first_heading_ff;
   logic [15:0]              first_width_ff, first_length_ff;
   logic [15:0]              first_height_ff, first_radius_ff;

   // object under test
   logic [POSITION_BITS-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic [8:0]               cur_heading_ff;
   logic [15:0]              cur_width_ff, cur_length_ff;
   logic [15:0]              cur_height_ff, cur_radius_ff;

   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [15:0]   s0_ff, c0_ff, s1_ff, c1_ff;
   logic signed [32:0]   dot_ff;
   logic signed [51:0]   center_ff, reach_ff;
   logic                 rsp_valid_ff, rsp_colliding_ff;
   logic                 reject_flag, gap_flag;

   // first object, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff       <= '0;
         first_y_ff       <= '0;
         first_z_ff       <= '0;
         first_heading_ff <= '0;
         first_width_ff   <= '0;
         first_length_ff  <= '0;
         first_height_ff  <= '0;
         first_radius_ff  <= '0;
      end else if (cmd.op == OP_STORE) begin
         first_x_ff       <= req_pos_x;
         first_y_ff       <= req_pos_y;
         first_z_ff       <= req_pos_z;
         first_heading_ff <= req_heading_deg;
         first_width_ff   <= req_width;
         first_length_ff  <= req_length;
         first_height_ff  <= req_height;
         first_radius_ff  <= req_bound_radius;
      end
   end

   // tested object capture
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         cur_x_ff       <= req_pos_x;
         cur_y_ff       <= req_pos_y;
         cur_z_ff       <= req_pos_z;
         cur_heading_ff <= req_heading_deg;
         cur_width_ff   <= req_width;
         cur_length_ff  <= req_length;
         cur_height_ff  <= req_height;
         cur_radius_ff  <= req_bound_radius;
      end
   end

   // center differences
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIFF) begin
         dx_ff <= {first_x_ff[POSITION_BITS-1], first_x_ff}
                - {cur_x_ff[POSITION_BITS-1], cur_x_ff};
         dy_ff <= {first_y_ff[POSITION_BITS-1], first_y_ff}
                - {cur_y_ff[POSITION_BITS-1], cur_y_ff};
         dz_ff <= {first_z_ff[POSITION_BITS-1], first_z_ff}
                - {cur_z_ff[POSITION_BITS-1], cur_z_ff};
      end
   end

   // height and bounding radius pre-check
   logic [DW-1:0] abs_dx, abs_dy, abs_dz;
   logic [15:0]   hmax;
   logic [16:0]   rsum;
   always_comb begin
      abs_dx = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      abs_dy = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
      abs_dz = dz_ff[DW-1] ? DW'(-dz_ff) : DW'(dz_ff);
      hmax   = (cur_height_ff > first_height_ff) ? cur_height_ff : first_height_ff;
      rsum   = {1'b0, first_radius_ff} + {1'b0, cur_radius_ff};
      reject_flag = ({abs_dz, 1'b0} > (DW + 1)'(hmax))
                 || (abs_dx > DW'(rsum)) || (abs_dy > DW'(rsum));
   end

   // sine/cosine lookup: term selects s0, c0, s1, c1
   logic [8:0]         angle_raw, angle_base, angle_shift, angle_wrap, angle;
   logic signed [15:0] trig_val;
   always_comb begin
      angle_raw   = cmd.term[1] ? cur_heading_ff : first_heading_ff;
      angle_base  = (angle_raw >= 9'(ANGLE_STEPS)) ? angle_raw - 9'(ANGLE_STEPS)
                                                   : angle_raw;
      angle_shift = angle_base + 9'(QUARTER_TURN);
      angle_wrap  = (angle_shift >= 9'(ANGLE_STEPS)) ? angle_shift - 9'(ANGLE_STEPS)
                                                     : angle_shift;
      angle       = cmd.term[0] ? angle_wrap : angle_base;
      trig_val    = sine_q15(angle);
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_TRIG) begin
         case (cmd.term)
            2'd0:    s0_ff <= trig_val;
            2'd1:    c0_ff <= trig_val;
            2'd2:    s1_ff <= trig_val;
            default: c1_ff <= trig_val;
         endcase
      end
   end

   // edge directions: u0, v0, u1, v1 and their extents
   logic signed [15:0] axis_x, axis_y, term_x, term_y;
   logic [15:0]        axis_ext, term_ext;
   always_comb begin
      case (cmd.axis)
         2'd0:    begin axis_x = c0_ff;  axis_y = s0_ff; axis_ext = first_width_ff;  end
         2'd1:    begin axis_x = -s0_ff; axis_y = c0_ff; axis_ext = first_length_ff; end
         2'd2:    begin axis_x = c1_ff;  axis_y = s1_ff; axis_ext = cur_width_ff;    end
         default: begin axis_x = -s1_ff; axis_y = c1_ff; axis_ext = cur_length_ff;   end
      endcase
      case (cmd.term)
         2'd0:    begin term_x = c0_ff;  term_y = s0_ff; term_ext = first_width_ff;  end
         2'd1:    begin term_x = -s0_ff; term_y = c0_ff; term_ext = first_length_ff; end
         2'd2:    begin term_x = c1_ff;  term_y = s1_ff; term_ext = cur_width_ff;    end
         default: begin term_x = -s1_ff; term_y = c1_ff; term_ext = cur_length_ff;   end
      endcase
   end

   // shared multiplier operand select
   logic signed [18:0] dx2, dy2;
   logic [32:0]        abs_dot;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] product;
   always_comb begin
      dx2     = 19'(dx_ff) <<< 1;
      dy2     = 19'(dy_ff) <<< 1;
      abs_dot = dot_ff[32] ? 33'(-dot_ff) : 33'(dot_ff);
      mul_a   = 34'(dx2);
      mul_b   = 17'(axis_x);
      case (cmd.op)
         OP_CENTER_Y: begin mul_a = 34'(dy2);    mul_b = 17'(axis_y); end
         OP_DOT_X:    begin mul_a = 34'(term_x); mul_b = 17'(axis_x); end
         OP_DOT_Y:    begin mul_a = 34'(term_y); mul_b = 17'(axis_y); end
         OP_REACH: begin
            mul_a = signed'({1'b0, abs_dot});
            mul_b = signed'({1'b0, term_ext});
         end
         default: begin
            mul_a = 34'(dx2);
            mul_b = 17'(axis_x);
         end
      endcase
      product = mul_a * mul_b;
   end

   // projection accumulators
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CENTER_X: begin
            center_ff <= 52'(product);
            reach_ff  <= '0;
         end
         OP_CENTER_Y: center_ff <= center_ff + 52'(product);
         OP_DOT_X:    dot_ff    <= 33'(product);
         OP_DOT_Y:    dot_ff    <= dot_ff + 33'(product);
         OP_REACH:    reach_ff  <= reach_ff + 52'(product);
         default:     ;
      endcase
   end

   // gap on current axis: scaled center distance beyond both reaches
   logic [51:0] abs_center;
   always_comb begin
      abs_center = center_ff[51] ? 52'(-center_ff) : 52'(center_ff);
      gap_flag   = (axis_ext != '0)
                && ({abs_center[36:0], 15'd0} > unsigned'(reach_ff));
   end

   assign status = '{reject: reject_flag, gap: gap_flag};

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == OP_HIT) || (cmd.op == OP_MISS);
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_HIT) || (cmd.op == OP_MISS)) begin
         rsp_colliding_ff <= (cmd.op == OP_HIT);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_colliding = rsp_colliding_ff;

endmodule

// ===== rtl/obc_checker.sv =====
module obc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_valid
);

   // a store request never occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_action) |=> !busy)
      else $error("store request made the block busy");

   // a test request occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action) |=> busy)
      else $error("test request did not make the block busy");

   // every test ends with a result strobe
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("test finished without a result");

   // results only appear once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

endmodule

bind oriented_box_collision_test_core obc_checker u_obc_checker (.*);
